// ----- hw/rtl/pidmc_pkg.sv -----
// ----------------------------------------------------------------------------
// pidmc_pkg: shared types and constants
// Widths, register indexes, codes and pipeline word types of the PID core.
// ----------------------------------------------------------------------------
package pidmc_pkg;

    localparam int MEAS_W     = 16;
    localparam int ERR_W      = 17;
    localparam int DIFF_W     = 18;
    localparam int GAIN_W     = 32;
    localparam int INTEG_W    = 32;
    localparam int SUM_W      = 64;
    localparam int PROD_E_W   = GAIN_W + ERR_W;
    localparam int PROD_D_W   = GAIN_W + DIFF_W;
    localparam int FRAC_W     = 24;
    localparam int CLAMP_W    = FRAC_W + 2;
    localparam int SCALED_W   = 32;
    localparam int DUTY_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MODE_W     = 2;

    localparam logic signed [SUM_W-1:0] ONE_Q24     = SUM_W'(64'sd16777216);
    localparam logic signed [SUM_W-1:0] NEG_ONE_Q24 = -ONE_Q24;
    localparam logic signed [SCALED_W-1:0] DUTY_SCALE = SCALED_W'(32'sd100);
    localparam logic signed [SCALED_W-1:0] TRUNC_BIAS = SCALED_W'((64'sd1 <<< FRAC_W) - 1);
    localparam logic signed [DUTY_W-1:0] DUTY_MAX = DUTY_W'(8'sd100);
    localparam logic signed [DUTY_W-1:0] DUTY_MIN = -DUTY_MAX;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT = 3'd0,
        REG_MODE     = 3'd1,
        REG_KP       = 3'd2,
        REG_KI       = 3'd3,
        REG_KD       = 3'd4
    } reg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF  = 2'd0,
        MODE_VEL  = 2'd1,
        MODE_POS  = 2'd2,
        MODE_HOLD = 2'd3
    } mode_t;

    typedef struct packed {
        logic signed [MEAS_W-1:0] setpoint;
        mode_t                    mode;
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
    } cfg_t;

    typedef struct packed {
        logic                     clr;
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] diff;
    } front_word_t;

    typedef struct packed {
        logic                       clr;
        logic signed [ERR_W-1:0]    err;
        logic signed [PROD_E_W-1:0] kpe;
        logic signed [PROD_D_W-1:0] kdd;
        logic signed [PROD_E_W-1:0] kie;
    } prod_word_t;

    typedef struct packed {
        logic                       clr;
        logic signed [ERR_W-1:0]    err;
        logic signed [SUM_W-1:0]    a;
        logic signed [SUM_W-1:0]    bn;
        logic signed [SUM_W-1:0]    bmax;
        logic signed [SUM_W-1:0]    bmin;
        logic signed [PROD_E_W-1:0] kie;
    } sum_word_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] kimax;
        logic signed [SUM_W-1:0] kimin;
    } ki_bound_t;

endpackage

// ----- hw/rtl/pidmc_if.sv -----
// ----------------------------------------------------------------------------
// pidmc_if: stream channels of the PID core
// Sample channel in, duty channel out, valid/ready with payload.
// ----------------------------------------------------------------------------
interface pidmc_sample_if;
    import pidmc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic signed [MEAS_W-1:0] measured_velocity;
    logic signed [MEAS_W-1:0] measured_position;

    modport source (
        output valid, cmd, measured_velocity, measured_position,
        input  ready
    );
    modport sink (
        input  valid, cmd, measured_velocity, measured_position,
        output ready
    );
endinterface

interface pidmc_duty_if;
    import pidmc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DUTY_W-1:0] duty_cycle;

    modport source (
        output valid, duty_cycle,
        input  ready
    );
    modport sink (
        input  valid, duty_cycle,
        output ready
    );
endinterface

// ----- hw/rtl/pidmc_front.sv -----
// ----------------------------------------------------------------------------
// pidmc_front: input register and error stage
// Registers the sample word, forms error and derivative, keeps previous error.
// ----------------------------------------------------------------------------
module pidmc_front (
    input  logic                    clk,
    input  logic                    rst_n,
    pidmc_sample_if.sink            sample_in,
    input  pidmc_pkg::cfg_t         cfg,
    input  logic                    busy,
    output logic                    f_valid,
    output pidmc_pkg::front_word_t  f_word,
    input  logic                    f_ready
);
    import pidmc_pkg::*;

    logic                     in_valid_reg;
    logic                     cmd_reg;
    logic signed [MEAS_W-1:0] vel_reg;
    logic signed [MEAS_W-1:0] pos_reg;
    logic signed [ERR_W-1:0]  prev_err_reg;
    logic signed [ERR_W-1:0]  prev_err_next;
    logic                     out_valid_reg;
    front_word_t              out_word_reg;

    logic                     ld_out;
    logic                     ld_in;
    logic                     accept;
    logic                     keep;
    logic                     fire;
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;

    assign ld_out          = !out_valid_reg || f_ready;
    assign ld_in           = !in_valid_reg || ld_out;
    assign sample_in.ready = ld_in && !busy;
    assign accept          = sample_in.valid && sample_in.ready;
    assign keep            = (cmd_reg == CMD_CLEAR) || (cfg.mode != MODE_OFF);
    assign fire            = in_valid_reg && ld_out && keep;

    always_comb
    begin
        unique case (cfg.mode)
            MODE_VEL:  err = ERR_W'(cfg.setpoint) - ERR_W'(vel_reg);
            MODE_POS:  err = ERR_W'(cfg.setpoint) - ERR_W'(pos_reg);
            MODE_HOLD: err = prev_err_reg;
            MODE_OFF:  err = prev_err_reg;
        endcase
        diff = DIFF_W'(err) - DIFF_W'(prev_err_reg);
    end

    always_comb
    begin
        prev_err_next = prev_err_reg;
        if (fire)
        begin
            prev_err_next = (cmd_reg == CMD_CLEAR) ? '0 : err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_err_reg  <= '0;
        end
        else
        begin
            if (ld_in)
            begin
                in_valid_reg <= accept;
            end
            if (ld_out)
            begin
                out_valid_reg <= in_valid_reg && keep;
            end
            prev_err_reg <= prev_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= sample_in.cmd;
            vel_reg <= sample_in.measured_velocity;
            pos_reg <= sample_in.measured_position;
        end
        if (fire)
        begin
            out_word_reg.clr  <= (cmd_reg == CMD_CLEAR);
            out_word_reg.err  <= err;
            out_word_reg.diff <= diff;
        end
    end

    assign f_valid = out_valid_reg;
    assign f_word  = out_word_reg;

    // drop a sample while the loop is off
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && cmd_reg != CMD_CLEAR && cfg.mode == MODE_OFF && ld_out)
            |=> !out_valid_reg)
        else $error("sample in off mode reached the product stage");

    // clear zeroes the previous error
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd_reg == CMD_CLEAR) |=> prev_err_reg == '0)
        else $error("previous error not cleared");

    // hold input while the gain product is rebuilt
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !accept)
        else $error("word accepted during recompute");

endmodule

// ----- hw/rtl/pidmc_mult.sv -----
// ----------------------------------------------------------------------------
// pidmc_mult: gain products and partial sums
// Multiplies error and derivative by the gains, then forms candidate sums.
// ----------------------------------------------------------------------------
module pidmc_mult (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pidmc_pkg::cfg_t         cfg,
    input  pidmc_pkg::ki_bound_t    bounds,
    input  logic                    f_valid,
    input  pidmc_pkg::front_word_t  f_word,
    output logic                    f_ready,
    output logic                    s_valid,
    output pidmc_pkg::sum_word_t    s_word,
    input  logic                    s_ready
);
    import pidmc_pkg::*;

    logic       m_valid_reg;
    prod_word_t m_word_reg;
    logic       s_valid_reg;
    sum_word_t  s_word_reg;

    logic                    ld_m;
    logic                    ld_s;
    logic signed [SUM_W-1:0] a;

    assign ld_s    = !s_valid_reg || s_ready;
    assign ld_m    = !m_valid_reg || ld_s;
    assign f_ready = ld_m;

    assign a = SUM_W'(m_word_reg.kpe) + SUM_W'(m_word_reg.kdd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld_m)
            begin
                m_valid_reg <= f_valid;
            end
            if (ld_s)
            begin
                s_valid_reg <= m_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_m && f_valid)
        begin
            m_word_reg.clr <= f_word.clr;
            m_word_reg.err <= f_word.err;
            m_word_reg.kpe <= PROD_E_W'(cfg.kp) * PROD_E_W'(f_word.err);
            m_word_reg.kdd <= PROD_D_W'(cfg.kd) * PROD_D_W'(f_word.diff);
            m_word_reg.kie <= PROD_E_W'(cfg.ki) * PROD_E_W'(f_word.err);
        end
        if (ld_s && m_valid_reg)
        begin
            s_word_reg.clr  <= m_word_reg.clr;
            s_word_reg.err  <= m_word_reg.err;
            s_word_reg.a    <= a;
            s_word_reg.bn   <= SUM_W'(m_word_reg.kpe) + SUM_W'(m_word_reg.kdd)
                               + SUM_W'(m_word_reg.kie);
            s_word_reg.bmax <= a + bounds.kimax;
            s_word_reg.bmin <= a + bounds.kimin;
            s_word_reg.kie  <= m_word_reg.kie;
        end
    end

    assign s_valid = s_valid_reg;
    assign s_word  = s_word_reg;

    // advance a word only into a free or draining stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid_reg && !s_ready) |=> s_valid_reg)
        else $error("stalled word lost in sum stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !ld_s) |=> m_valid_reg)
        else $error("stalled word lost in product stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && ld_s) |=> s_valid_reg)
        else $error("product word not moved to sum stage");

endmodule

// ----- hw/rtl/pidmc_loop.sv -----
// ----------------------------------------------------------------------------
// pidmc_loop: integral state and anti-windup
// Updates the saturating integral and its gain product, picks the output sum.
// ----------------------------------------------------------------------------
module pidmc_loop (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [pidmc_pkg::GAIN_W-1:0] ki,
    input  logic                          ki_wr,
    output logic                          busy,
    output pidmc_pkg::ki_bound_t          bounds,
    input  logic                          s_valid,
    input  pidmc_pkg::sum_word_t          s_word,
    output logic                          s_ready,
    output logic                          l_valid,
    output logic signed [pidmc_pkg::SUM_W-1:0] l_sum,
    input  logic                          l_ready
);
    import pidmc_pkg::*;

    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [SUM_W-1:0]   ki_integ_reg;
    logic signed [SUM_W-1:0]   ki_integ_next;
    logic signed [SUM_W-1:0]   kimax_reg;
    logic signed [SUM_W-1:0]   kimin_reg;
    logic                      busy_reg;
    logic                      l_valid_reg;
    logic signed [SUM_W-1:0]   l_sum_reg;

    logic                      ld_l;
    logic                      fire;
    logic signed [INTEG_W:0]   isum;
    logic                      sat_hi;
    logic                      sat_lo;
    logic signed [INTEG_W-1:0] isat;
    logic signed [SUM_W-1:0]   kint_add;
    logic signed [SUM_W-1:0]   ki_isat;
    logic signed [SUM_W-1:0]   sum_new;
    logic signed [SUM_W-1:0]   sum_old;
    logic signed [SUM_W-1:0]   sum_sel;
    logic                      windup;
    logic signed [SUM_W-1:0]   ki_prod;
    logic signed [SUM_W-1:0]   ki_shift;

    assign ld_l    = !l_valid_reg || l_ready;
    assign s_ready = ld_l;
    assign fire    = s_valid && ld_l;

    assign isum   = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(s_word.err);
    assign sat_hi = (isum[INTEG_W:INTEG_W-1] == 2'b01);
    assign sat_lo = (isum[INTEG_W:INTEG_W-1] == 2'b10);

    always_comb
    begin
        priority if (sat_hi)
        begin
            isat    = INTEG_MAX;
            ki_isat = kimax_reg;
            sum_new = s_word.bmax;
        end
        else if (sat_lo)
        begin
            isat    = INTEG_MIN;
            ki_isat = kimin_reg;
            sum_new = s_word.bmin;
        end
        else
        begin
            isat    = isum[INTEG_W-1:0];
            ki_isat = kint_add;
            sum_new = ki_integ_reg + s_word.bn;
        end
    end

    assign kint_add = ki_integ_reg + SUM_W'(s_word.kie);
    assign sum_old  = ki_integ_reg + s_word.a;
    assign windup   = (sum_new > ONE_Q24) || (sum_new < NEG_ONE_Q24);
    assign sum_sel  = windup ? sum_old : sum_new;

    assign ki_prod  = SUM_W'(ki) * SUM_W'(integ_reg);
    assign ki_shift = SUM_W'(ki) <<< (INTEG_W - 1);

    always_comb
    begin
        integ_next    = integ_reg;
        ki_integ_next = ki_integ_reg;
        priority if (busy_reg)
        begin
            ki_integ_next = ki_prod;
        end
        else if (fire && s_word.clr)
        begin
            integ_next    = '0;
            ki_integ_next = '0;
        end
        else if (fire && !windup)
        begin
            integ_next    = isat;
            ki_integ_next = ki_isat;
        end
        else
        begin
            integ_next    = integ_reg;
            ki_integ_next = ki_integ_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg    <= '0;
            ki_integ_reg <= '0;
            kimax_reg    <= '0;
            kimin_reg    <= '0;
            busy_reg     <= 1'b0;
            l_valid_reg  <= 1'b0;
        end
        else
        begin
            integ_reg    <= integ_next;
            ki_integ_reg <= ki_integ_next;
            busy_reg     <= ki_wr;
            if (busy_reg)
            begin
                kimax_reg <= ki_shift - SUM_W'(ki);
                kimin_reg <= -ki_shift;
            end
            if (ld_l)
            begin
                l_valid_reg <= s_valid && !s_word.clr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            l_sum_reg <= sum_sel;
        end
    end

    assign busy         = busy_reg;
    assign bounds.kimax = kimax_reg;
    assign bounds.kimin = kimin_reg;
    assign l_valid      = l_valid_reg;
    assign l_sum        = l_sum_reg;

    // clear zeroes the integral and its product
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s_word.clr && !busy_reg) |=> (integ_reg == '0 && ki_integ_reg == '0))
        else $error("integral not cleared");

    // undo this sample's integration on windup
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !s_word.clr && windup && !busy_reg) |=> $stable(integ_reg))
        else $error("integral moved on windup");

    // a clear word gives no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (ld_l && s_valid && s_word.clr) |=> !l_valid_reg)
        else $error("clear word produced a result");

endmodule

// ----- hw/rtl/pidmc_scale.sv -----
// ----------------------------------------------------------------------------
// pidmc_scale: clamp and duty conversion
// Clamps the sum to +-1.0, scales by 100, truncates toward zero to duty.
// ----------------------------------------------------------------------------
module pidmc_scale (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              l_valid,
    input  logic signed [pidmc_pkg::SUM_W-1:0] l_sum,
    output logic                              l_ready,
    pidmc_duty_if.source                      duty_out
);
    import pidmc_pkg::*;

    logic                       p_valid_reg;
    logic signed [SCALED_W-1:0] p_reg;
    logic                       duty_valid_reg;
    logic signed [DUTY_W-1:0]   duty_reg;

    logic                       ld_o;
    logic                       ld_p;
    logic signed [SUM_W-1:0]    csum;
    logic signed [CLAMP_W-1:0]  clamped;
    logic signed [SCALED_W-1:0] rnd;
    logic signed [SCALED_W-1:0] quot;

    assign ld_o    = !duty_valid_reg || duty_out.ready;
    assign ld_p    = !p_valid_reg || ld_o;
    assign l_ready = ld_p;

    always_comb
    begin
        priority if (l_sum > ONE_Q24)
        begin
            csum = ONE_Q24;
        end
        else if (l_sum < NEG_ONE_Q24)
        begin
            csum = NEG_ONE_Q24;
        end
        else
        begin
            csum = l_sum;
        end
    end

    assign clamped = csum[CLAMP_W-1:0];
    assign rnd     = p_reg + ((p_reg < 0) ? TRUNC_BIAS : SCALED_W'(0));
    assign quot    = rnd >>> FRAC_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg    <= 1'b0;
            duty_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld_p)
            begin
                p_valid_reg <= l_valid;
            end
            if (ld_o)
            begin
                duty_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_p && l_valid)
        begin
            p_reg <= SCALED_W'(clamped) * DUTY_SCALE;
        end
        if (ld_o && p_valid_reg)
        begin
            duty_reg <= quot[DUTY_W-1:0];
        end
    end

    assign duty_out.valid      = duty_valid_reg;
    assign duty_out.duty_cycle = duty_reg;

    // duty stays within +-100 percent
    assert property (@(posedge clk) disable iff (!rst_n)
        duty_valid_reg |-> (duty_reg <= DUTY_MAX && duty_reg >= DUTY_MIN))
        else $error("duty out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> (p_reg <= SCALED_W'(ONE_Q24) * DUTY_SCALE
                         && p_reg >= SCALED_W'(NEG_ONE_Q24) * DUTY_SCALE))
        else $error("scaled sum out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && ld_o) |=> duty_valid_reg)
        else $error("scaled word not moved to output");

endmodule

// ----- hw/rtl/pid_motor_controller_core.sv -----
// ----------------------------------------------------------------------------
// pid_motor_controller_core: positional PID motor controller
// Sample words in, signed duty words out; write port for setpoint, mode, gains.
// ----------------------------------------------------------------------------
// The core takes one sample word per clock while the output drains and no KI
// write is being handled. A word passes the input, error, product, sum, loop,
// scale and output registers; every stage has its own valid bit, so stalls at
// the output only fill bubbles first. Clear words and samples in off mode give
// no duty word. The integral and its gain product are updated in a single
// stage, so back-to-back samples see each other's state. Writing the KI gain
// rebuilds the gain-times-integral product with one 32x32 multiply, which holds
// the input off in the cycle after the write.
module pid_motor_controller_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    pidmc_sample_if.sink                         sample_in,
    pidmc_duty_if.source                         duty_out,
    input  logic                                 cfg_we,
    input  logic [pidmc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pidmc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import pidmc_pkg::*;

    cfg_t                    cfg_reg;
    logic                    ki_wr;
    logic                    busy;
    ki_bound_t               bounds;
    logic                    f_valid;
    front_word_t             f_word;
    logic                    f_ready;
    logic                    s_valid;
    sum_word_t               s_word;
    logic                    s_ready;
    logic                    l_valid;
    logic signed [SUM_W-1:0] l_sum;
    logic                    l_ready;

    assign ki_wr = cfg_we && (reg_idx_t'(cfg_index) == REG_KI);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint <= '0;
            cfg_reg.mode     <= MODE_OFF;
            cfg_reg.kp       <= '0;
            cfg_reg.ki       <= '0;
            cfg_reg.kd       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_SETPOINT: cfg_reg.setpoint <= cfg_wdata[MEAS_W-1:0];
                REG_MODE:     cfg_reg.mode     <= mode_t'(cfg_wdata[MODE_W-1:0]);
                REG_KP:       cfg_reg.kp       <= cfg_wdata[GAIN_W-1:0];
                REG_KI:       cfg_reg.ki       <= cfg_wdata[GAIN_W-1:0];
                REG_KD:       cfg_reg.kd       <= cfg_wdata[GAIN_W-1:0];
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    pidmc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sample_in),
        .cfg       (cfg_reg),
        .busy      (busy),
        .f_valid   (f_valid),
        .f_word    (f_word),
        .f_ready   (f_ready)
    );

    pidmc_mult u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .bounds  (bounds),
        .f_valid (f_valid),
        .f_word  (f_word),
        .f_ready (f_ready),
        .s_valid (s_valid),
        .s_word  (s_word),
        .s_ready (s_ready)
    );

    pidmc_loop u_loop (
        .clk     (clk),
        .rst_n   (rst_n),
        .ki      (cfg_reg.ki),
        .ki_wr   (ki_wr),
        .busy    (busy),
        .bounds  (bounds),
        .s_valid (s_valid),
        .s_word  (s_word),
        .s_ready (s_ready),
        .l_valid (l_valid),
        .l_sum   (l_sum),
        .l_ready (l_ready)
    );

    pidmc_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .l_valid  (l_valid),
        .l_sum    (l_sum),
        .l_ready  (l_ready),
        .duty_out (duty_out)
    );

endmodule
